// ----- hw/rtl/sevq_pkg.sv -----
// Package for the severity priority queue: widths, codes, entry and cell link types.
// It also holds the helper functions for severity levels and rooms.
// It depends on nothing; every other file of the block imports it.
package sevq_pkg;

	// Sizing of the waiting list.
	localparam int CAPACITY = 16;
	localparam int ID_BITS  = 16;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	// Field widths of the command and response items.
	localparam int PID_W    = 16;
	localparam int SEV_W    = 3;
	localparam int STATUS_W = 2;
	localparam int ROOM_W   = 2;
	localparam int WCNT_W   = 5;

	// Severity levels 0 to 4.
	localparam int SEV_LEVELS = 5;
	localparam int SEV_MAX    = 4;

	typedef logic [ID_BITS-1:0]    id_t;
	typedef logic [SEV_W-1:0]      sev_t;
	typedef logic [IDX_W-1:0]      idx_t;
	typedef logic [CNT_W-1:0]      cnt_t;
	typedef logic [SEV_LEVELS-1:0] lvl_t;

	typedef enum logic [0:0] {
		MODE_ADD  = 1'b0,
		MODE_CALL = 1'b1
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_ADDED  = 2'd0,
		STATUS_CALLED = 2'd1,
		STATUS_EMPTY  = 2'd2,
		STATUS_FULL   = 2'd3
	} status_t;

	typedef enum logic [ROOM_W-1:0] {
		ROOM_CONSULT = 2'd0,
		ROOM_EXAM    = 2'd1,
		ROOM_EMERG   = 2'd2
	} room_t;

	typedef enum logic [0:0] {
		ST_IDLE   = 1'b0,
		ST_COMMIT = 1'b1
	} state_t;

	// One waiting entry as held in a cell.
	typedef struct packed {
		id_t  id;
		sev_t sev;
	} entry_t;

	// Broadcast control from the sequencer to every cell.
	typedef struct packed {
		logic   append;
		logic   remove;
		sev_t   best;
		cnt_t   count;
		entry_t new_entry;
	} cell_ctrl_t;

	// Signals handed from one cell to the next along the row.
	typedef struct packed {
		logic hit;
		id_t  id;
		lvl_t lvl;
	} chain_t;

	// One-hot mark of a severity level.
	function automatic lvl_t lvl_of(input sev_t sev);
		return lvl_t'(1) << sev;
	endfunction

	// Highest severity above zero present in a level mask, or zero.
	function automatic sev_t best_of(input lvl_t lvl);
		sev_t best;
		best = '0;
		for (int k = 1; k <= SEV_MAX; k++) begin
			if (lvl[k]) begin
				best = sev_t'(k);
			end
		end
		return best;
	endfunction

	// Room that serves a given severity.
	function automatic room_t room_of(input sev_t sev);
		room_t room;
		case (sev)
			sev_t'(4): room = ROOM_EMERG;
			sev_t'(3): room = ROOM_EXAM;
			default:   room = ROOM_CONSULT;
		endcase
		return room;
	endfunction

endpackage

// ----- hw/rtl/sevq_if.sv -----
// Valid/ready channel interfaces for the command and response items.
// They depend on sevq_pkg for the field widths.
interface sevq_cmd_if;
	import sevq_pkg::*;

	logic             valid;
	logic             ready;
	logic             mode;
	logic [PID_W-1:0] patient_id;
	logic [SEV_W-1:0] severity;

	modport source(output valid, output mode, output patient_id, output severity,
		input ready);
	modport sink(input valid, input mode, input patient_id, input severity,
		output ready);
endinterface

interface sevq_rsp_if;
	import sevq_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [PID_W-1:0]    called_id;
	logic [ROOM_W-1:0]   room;
	logic [WCNT_W-1:0]   waiting_count;

	modport source(output valid, output status, output called_id, output room,
		output waiting_count, input ready);
	modport sink(input valid, input status, input called_id, input room,
		input waiting_count, output ready);
endinterface

// ----- hw/rtl/sevq_cell.sv -----
// One cell of the waiting list row: holds a single entry and passes level,
// hit and id information on to the next cell. Depends on sevq_pkg.
module sevq_cell (
	input  logic                   clk,
	input  sevq_pkg::cell_ctrl_t   ctrl,
	input  sevq_pkg::idx_t         cell_idx,
	input  sevq_pkg::chain_t       chain_in,
	output sevq_pkg::chain_t       chain_out,
	input  sevq_pkg::entry_t       right_entry,
	output sevq_pkg::entry_t       entry
);
	import sevq_pkg::*;

	entry_t entry_q;
	logic   valid;
	logic   match;

	// The cell holds a live entry when its place lies below the fill count.
	assign valid = CNT_W'(cell_idx) < ctrl.count;
	assign match = valid && (entry_q.sev == ctrl.best);

	// Pass on the levels seen so far, and the first entry at the best level.
	always_comb begin
		chain_out.hit = chain_in.hit | match;
		chain_out.lvl = chain_in.lvl | (valid ? lvl_of(entry_q.sev) : '0);
		if (chain_in.hit) begin
			chain_out.id = chain_in.id;
		end else if (match) begin
			chain_out.id = entry_q.id;
		end else begin
			chain_out.id = '0;
		end
	end

	// Load a new entry at the tail, or close the gap left by a removed entry.
	always_ff @(posedge clk) begin
		if (ctrl.append && (CNT_W'(cell_idx) == ctrl.count)) begin
			entry_q <= ctrl.new_entry;
		end else if (ctrl.remove && chain_out.hit) begin
			entry_q <= right_entry;
		end
	end

	assign entry = entry_q;

endmodule

// ----- hw/rtl/severity_priority_queue_unit.sv -----
// A command item is accepted only in the idle state, so a new command waits until the
// last one is through. The idle state scans the cell row for the highest severity; the
// commit state, which waits while an earlier response is still held, applies the append
// or the shift along the row and registers the result.
// Reset clears the fill count, the sequencer and the response slot; entry contents
// are left as they are and are only read below the fill count.
module severity_priority_queue_unit (
	input logic      clk,
	input logic      arst_n,
	sevq_cmd_if.sink   cmd,
	sevq_rsp_if.source rsp
);
	import sevq_pkg::*;

	state_t     state_q;
	state_t     state_next;
	cnt_t       count_q;
	cnt_t       count_next;
	logic       mode_q;
	entry_t     new_q;
	sev_t       best_q;
	logic       cmd_fire;
	logic       commit;
	logic       full;
	cell_ctrl_t ctrl;
	status_t    status_next;

	logic                rsp_valid_q;
	status_t             status_q;
	logic [PID_W-1:0]    called_id_q;
	room_t               room_q;
	logic [WCNT_W-1:0]   waiting_count_q;

	chain_t chain [CAPACITY+1];
	entry_t entries [CAPACITY];
	entry_t right [CAPACITY];

	// The row of cells.
	assign chain[0] = '0;
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		if (i == CAPACITY - 1) begin : g_last
			assign right[i] = entries[i];
		end else begin : g_mid
			assign right[i] = entries[i+1];
		end
		sevq_cell u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.cell_idx   (IDX_W'(i)),
			.chain_in   (chain[i]),
			.chain_out  (chain[i+1]),
			.right_entry(right[i]),
			.entry      (entries[i])
		);
	end

	// Next state.
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE:   if (cmd.valid) state_next = ST_COMMIT;
			ST_COMMIT: if (!rsp_valid_q || rsp.ready) state_next = ST_IDLE;
			default:   state_next = ST_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		cmd.ready = 1'b0;
		commit    = 1'b0;
		unique case (state_q)
			ST_IDLE:   cmd.ready = 1'b1;
			ST_COMMIT: commit = !rsp_valid_q || rsp.ready;
			default: ;
		endcase
	end

	assign cmd_fire = cmd.valid && cmd.ready;
	assign full     = count_q == CNT_W'(CAPACITY);

	// Broadcast control to the cells.
	always_comb begin
		ctrl.append    = commit && (mode_q == MODE_ADD) && !full;
		ctrl.remove    = commit && (mode_q == MODE_CALL) && (best_q != '0);
		ctrl.best      = best_q;
		ctrl.count     = count_q;
		ctrl.new_entry = new_q;
	end

	// Result status and the fill count after the item.
	always_comb begin
		count_next = count_q;
		if (mode_q == MODE_ADD) begin
			status_next = full ? STATUS_FULL : STATUS_ADDED;
			if (!full) count_next = count_q + CNT_W'(1);
		end else begin
			status_next = (best_q != '0) ? STATUS_CALLED : STATUS_EMPTY;
			if (best_q != '0) count_next = count_q - CNT_W'(1);
		end
	end

	// Sequencer state and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_next;
			if (commit) count_q <= count_next;
		end
	end

	// Command capture; the best level is taken from the row while it is steady.
	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			mode_q     <= cmd.mode;
			new_q.id   <= ID_BITS'(cmd.patient_id);
			new_q.sev  <= (cmd.severity > SEV_W'(SEV_MAX)) ? '0 : cmd.severity;
			best_q     <= best_of(chain[CAPACITY].lvl);
		end
	end

	// Response slot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (commit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			status_q        <= status_next;
			called_id_q     <= ctrl.remove ? PID_W'(chain[CAPACITY].id) : '0;
			room_q          <= ctrl.remove ? room_of(best_q) : ROOM_CONSULT;
			waiting_count_q <= WCNT_W'(count_next);
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.status        = status_q;
	assign rsp.called_id     = called_id_q;
	assign rsp.room          = room_q;
	assign rsp.waiting_count = waiting_count_q;

	// The fill count never passes the capacity.
	assert property (@(posedge clk) disable iff (!arst_n) count_q <= CNT_W'(CAPACITY))
		else $error("fill count above capacity");

	// A removal always finds an entry at the best level in the row.
	assert property (@(posedge clk) disable iff (!arst_n) ctrl.remove |-> chain[CAPACITY].hit)
		else $error("removal without a matching cell");

	// A removal shortens the list by exactly one.
	assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.remove |=> count_q == $past(count_q) - CNT_W'(1))
		else $error("fill count not decremented on removal");

	// A dropped add is reported only with a full list.
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && status_q == STATUS_FULL) |-> waiting_count_q == WCNT_W'(CAPACITY))
		else $error("full status with a list that is not full");

endmodule
